### hw/rtl/sorted_double_ended_priority_queue_top_assert.svh
// Assertion macros for the sorted double-ended priority queue
`ifndef SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// check cons in the same cycle as ante
`define SDEPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// check cons in the cycle after ante
`define SDEPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDEPQ_ASSERT_NOW(label, ante, cons, msg)
`define SDEPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/sdepq_pkg.sv
// Shared types and codes for the sorted double-ended priority queue
package sdepq_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int OCC_W = 7;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_POP_MIN = 2'd1;
    localparam logic [1:0] CMD_POP_MAX = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD      = 2'd0,
        OP_INSERT    = 2'd1,
        OP_POP_FRONT = 2'd2,
        OP_POP_BACK  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_entry;

    typedef struct packed {
        t_cell_op           op;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
    } t_cell_ctrl;

endpackage

### hw/rtl/sorted_double_ended_priority_queue_top.sv
// Top level of the sorted double-ended priority queue
//
//  channel   dir  handshake             payload
//  s (cmd)   in   i_s_tvalid/o_s_tready  tuser: command; tdata: key, value
//  m (rsp)   out  o_m_tvalid/i_m_tready  tuser: ok; tdata: out_key, out_value, occupancy
//
// One command per cycle unless stalled; its result beat shows in the next cycle.
// Two mirrored cell rows (ascending and descending) hold the same pairs, so both the
// smallest and the largest key always sit in slot zero of a row.
// The result register stalls new commands only while a beat waits and i_m_tready is low.
// Reset (i_rst_n low at a clock edge) empties both rows and the result register.
`include "sorted_double_ended_priority_queue_top_assert.svh"

module sorted_double_ended_priority_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] key, [63:32] value
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [31:0] out_key, [63:32] out_value, [70:64] occupancy
    output logic        o_m_tuser    // [0] ok
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    sdepq_pkg::t_cell_ctrl w_ctrl_asc;
    sdepq_pkg::t_cell_ctrl w_ctrl_desc;
    sdepq_pkg::t_entry     w_front_asc;
    sdepq_pkg::t_entry     w_front_desc;

    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic                          n_ok;
    logic [sdepq_pkg::KEY_W-1:0]   n_key;
    logic [sdepq_pkg::VAL_W-1:0]   n_value;

    logic                          r_out_valid;
    logic                          r_ok;
    logic [sdepq_pkg::KEY_W-1:0]   r_key;
    logic [sdepq_pkg::VAL_W-1:0]   r_value;
    logic [sdepq_pkg::OCC_W-1:0]   r_occ;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = r_count == CNT_W'(CAPACITY);
    assign w_empty    = r_count == '0;

    always_comb begin
        n_ok              = 1'b0;
        n_count           = r_count;
        n_key             = '0;
        n_value           = '0;
        w_ctrl_asc.op     = sdepq_pkg::OP_HOLD;
        w_ctrl_asc.key    = i_s_tdata[31:0];
        w_ctrl_asc.value  = i_s_tdata[63:32];
        w_ctrl_desc.op    = sdepq_pkg::OP_HOLD;
        w_ctrl_desc.key   = i_s_tdata[31:0];
        w_ctrl_desc.value = i_s_tdata[63:32];
        if (w_accept) begin
            case (i_s_tuser)
                sdepq_pkg::CMD_INSERT: begin
                    if (!w_full) begin
                        n_ok           = 1'b1;
                        n_count        = r_count + 1'b1;
                        w_ctrl_asc.op  = sdepq_pkg::OP_INSERT;
                        w_ctrl_desc.op = sdepq_pkg::OP_INSERT;
                    end
                end
                sdepq_pkg::CMD_POP_MIN: begin
                    if (!w_empty) begin
                        n_ok           = 1'b1;
                        n_count        = r_count - 1'b1;
                        n_key          = w_front_asc.key;
                        n_value        = w_front_asc.value;
                        w_ctrl_asc.op  = sdepq_pkg::OP_POP_FRONT;
                        w_ctrl_desc.op = sdepq_pkg::OP_POP_BACK;
                    end
                end
                sdepq_pkg::CMD_POP_MAX: begin
                    if (!w_empty) begin
                        n_ok           = 1'b1;
                        n_count        = r_count - 1'b1;
                        n_key          = w_front_desc.key;
                        n_value        = w_front_desc.value;
                        w_ctrl_asc.op  = sdepq_pkg::OP_POP_BACK;
                        w_ctrl_desc.op = sdepq_pkg::OP_POP_FRONT;
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
    end

    sdepq_chain #(
        .DEPTH  (CAPACITY),
        .DESCEND(1'b0)
    ) u_chain_asc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl_asc),
        .o_front(w_front_asc)
    );

    sdepq_chain #(
        .DEPTH  (CAPACITY),
        .DESCEND(1'b1)
    ) u_chain_desc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_ctrl_desc),
        .o_front(w_front_desc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok    <= n_ok;
            r_key   <= n_key;
            r_value <= n_value;
            r_occ   <= sdepq_pkg::OCC_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_ok;
    assign o_m_tdata  = {1'b0, r_occ, r_value, r_key};

    `SDEPQ_ASSERT_NOW(a_front_matches_count, 1'b1, (r_count != '0) == w_front_asc.valid && (r_count != '0) == w_front_desc.valid, "front slots disagree with count")
    `SDEPQ_ASSERT_NOW(a_min_not_above_max, w_front_asc.valid, $signed(w_front_asc.key) <= $signed(w_front_desc.key), "smallest key above largest key")
    `SDEPQ_ASSERT_NEXT(a_insert_counts, w_accept && i_s_tuser == sdepq_pkg::CMD_INSERT && !w_full, r_count == $past(r_count) + 1'b1, "insert did not raise count")

endmodule

### hw/rtl/sdepq_cell.sv
// One slot of the sorted chain: holds a pair and trades it with its neighbors
module sdepq_cell #(
    parameter bit DESCEND = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdepq_pkg::t_cell_ctrl i_ctrl,
    input  sdepq_pkg::t_entry   i_left,
    input  logic                i_left_place,
    input  sdepq_pkg::t_entry   i_right,
    output sdepq_pkg::t_entry   o_entry,
    output logic                o_place
);

    sdepq_pkg::t_entry r_entry;
    sdepq_pkg::t_entry n_entry;
    logic              w_less;

    assign w_less = $signed(r_entry.key) < $signed(i_ctrl.key);

    // new pair lands at or before this slot; ascending puts it ahead of equal keys,
    // descending (reverse order) puts it behind them
    assign o_place = !r_entry.valid || (DESCEND ? w_less : !w_less);

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            sdepq_pkg::OP_INSERT: begin
                if (i_left_place) begin
                    n_entry = i_left;
                end else if (o_place) begin
                    n_entry.valid = 1'b1;
                    n_entry.key   = i_ctrl.key;
                    n_entry.value = i_ctrl.value;
                end
            end
            sdepq_pkg::OP_POP_FRONT: begin
                n_entry = i_right;
            end
            sdepq_pkg::OP_POP_BACK: begin
                // drop the last occupied slot
                if (r_entry.valid && !i_right.valid) begin
                    n_entry.valid = 1'b0;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry.key   <= n_entry.key;
        r_entry.value <= n_entry.value;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/sdepq_chain.sv
// Row of sorted cells; slot zero is the front of the order
module sdepq_chain #(
    parameter int DEPTH   = 64,
    parameter bit DESCEND = 1'b0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sdepq_pkg::t_cell_ctrl i_ctrl,
    output sdepq_pkg::t_entry     o_front
);

    sdepq_pkg::t_entry w_entry [DEPTH];
    logic              w_place [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sdepq_pkg::t_entry w_left;
        sdepq_pkg::t_entry w_right;
        logic              w_left_place;

        if (g == 0) begin : g_first
            assign w_left       = '0;
            assign w_left_place = 1'b0;
        end else begin : g_mid_l
            assign w_left       = w_entry[g-1];
            assign w_left_place = w_place[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        sdepq_cell #(
            .DESCEND(DESCEND)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_left      (w_left),
            .i_left_place(w_left_place),
            .i_right     (w_right),
            .o_entry     (w_entry[g]),
            .o_place     (w_place[g])
        );
    end

    assign o_front = w_entry[0];

endmodule

### sim/sdepq_checker.sv
// Checker that predicts and compares result beats of the sorted priority queue
`timescale 1ns / 100ps

module sdepq_checker #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] key, [63:32] value
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,   // [31:0] out_key, [63:32] out_value, [70:64] occupancy
    input  logic        i_m_tuser,   // [0] ok
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_refusals,
    output int          o_peak
);

    typedef struct packed {
        logic signed [sdepq_pkg::KEY_W-1:0] key;
        logic signed [sdepq_pkg::VAL_W-1:0] value;
    } t_pair;

    typedef struct packed {
        logic                        ok;
        logic [sdepq_pkg::KEY_W-1:0] key;
        logic [sdepq_pkg::VAL_W-1:0] value;
        logic [sdepq_pkg::OCC_W-1:0] occupancy;
    } t_reply;

    // ascending by key; among equal keys the newest sits first
    t_pair  sorted_pairs[$];
    t_reply awaited_replies[$];
    t_reply want;

    function automatic t_reply apply_command(input logic [1:0] cmd,
                                             input logic [sdepq_pkg::KEY_W-1:0] key,
                                             input logic [sdepq_pkg::VAL_W-1:0] value);
        t_reply r;
        t_pair  p;
        int     pos;
        r = '0;
        case (cmd)
            sdepq_pkg::CMD_INSERT: begin
                if (sorted_pairs.size() < DEPTH) begin
                    pos = 0;
                    while (pos < sorted_pairs.size() &&
                           $signed(sorted_pairs[pos].key) < $signed(key))
                        pos++;
                    p.key   = key;
                    p.value = value;
                    sorted_pairs.insert(pos, p);
                    r.ok = 1'b1;
                end
            end
            sdepq_pkg::CMD_POP_MIN: begin
                if (sorted_pairs.size() > 0) begin
                    p       = sorted_pairs.pop_front();
                    r.ok    = 1'b1;
                    r.key   = p.key;
                    r.value = p.value;
                end
            end
            sdepq_pkg::CMD_POP_MAX: begin
                if (sorted_pairs.size() > 0) begin
                    p       = sorted_pairs.pop_back();
                    r.ok    = 1'b1;
                    r.key   = p.key;
                    r.value = p.value;
                end
            end
            default: ;  // reserved code: no change, refused
        endcase
        r.occupancy = sdepq_pkg::OCC_W'(sorted_pairs.size());
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] expected_val,
                                 input logic [63:0] got_val);
        o_errors++;
        $display("MISMATCH beat %0d %s: expected %h got %h @%0t",
                 o_results, field, expected_val, got_val, $realtime);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sorted_pairs.delete();
            awaited_replies.delete();
            o_errors   = 0;
            o_results  = 0;
            o_refusals = 0;
            o_peak     = 0;
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_replies.size() == 0) begin
                    flag_mismatch("beat with nothing expected", 64'd0, i_m_tdata[63:0]);
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_m_tuser !== want.ok)
                        flag_mismatch("ok", 64'(want.ok), 64'(i_m_tuser));
                    if (i_m_tdata[31:0] !== want.key)
                        flag_mismatch("out_key", 64'(want.key), 64'(i_m_tdata[31:0]));
                    if (i_m_tdata[63:32] !== want.value)
                        flag_mismatch("out_value", 64'(want.value), 64'(i_m_tdata[63:32]));
                    if (i_m_tdata[70:64] !== want.occupancy)
                        flag_mismatch("occupancy", 64'(want.occupancy),
                                      64'(i_m_tdata[70:64]));
                    if (i_m_tdata[71] !== 1'b0)
                        flag_mismatch("pad bit", 64'd0, 64'(i_m_tdata[71]));
                    if (!want.ok)
                        o_refusals++;
                end
                o_results++;
            end
            if (i_s_tvalid && i_s_tready) begin
                awaited_replies.push_back(
                    apply_command(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32]));
                if (sorted_pairs.size() > o_peak)
                    o_peak = sorted_pairs.size();
            end
            o_pending <= awaited_replies.size();
        end
    end

endmodule

### sim/tb_top.sv
// Stimulus and verdict for the sorted double-ended priority queue
`timescale 1ns / 100ps

module tb_top;

    localparam int         DEPTH        = 64;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int         IDLE_PCT     = 22;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         RANDOM_ITEMS = 830;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata  = '0;   // [31:0] key, [63:32] value
    logic [1:0]  i_s_tuser  = sdepq_pkg::CMD_INSERT;   // [1:0] command
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;         // [31:0] out_key, [63:32] out_value, [70:64] occupancy
    logic        o_m_tuser;         // [0] ok

    int err_count;
    int pending;
    int result_count;
    int refusal_count;
    int peak_occupancy;
    int sent_by_cmd[4];
    int quiet_cycles = 0;
    bit steady       = 1'b0;

    always #6 i_clk = ~i_clk;

    sorted_double_ended_priority_queue_top #(
        .CAPACITY (DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    sdepq_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .o_errors   (err_count),
        .o_pending  (pending),
        .o_results  (result_count),
        .o_refusals (refusal_count),
        .o_peak     (peak_occupancy)
    );

    // stall the result side at random, except in the steady stretch
    always @(posedge i_clk) begin
        if (steady)
            i_m_tready <= 1'b1;
        else
            i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] key,
                            input logic [31:0] value);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {value, key};
        do @(posedge i_clk); while (!o_s_tready);
        sent_by_cmd[cmd]++;
    endtask

    initial begin
        int         sent;
        int         n;
        int         run_len;
        int         mode;
        int         key_span;
        int         pick;
        int         narrow;
        logic [1:0] cmd;
        logic [31:0] key;

        foreach (sent_by_cmd[c]) sent_by_cmd[c] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, extreme keys, equal keys, reserved code, drain to empty
        send_cmd(sdepq_pkg::CMD_POP_MIN, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_POP_MAX, $urandom(), $urandom());
        send_cmd(CMD_RESERVED, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(sdepq_pkg::CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(sdepq_pkg::CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_cmd(sdepq_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_cmd(sdepq_pkg::CMD_INSERT, 32'd5, 32'd1);
        send_cmd(sdepq_pkg::CMD_INSERT, 32'd5, 32'd2);
        send_cmd(sdepq_pkg::CMD_INSERT, 32'd5, 32'd3);
        send_cmd(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(sdepq_pkg::CMD_POP_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(sdepq_pkg::CMD_POP_MAX, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_POP_MIN, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_POP_MIN, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_POP_MIN, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_POP_MAX, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_POP_MAX, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_POP_MAX, $urandom(), $urandom());
        send_cmd(sdepq_pkg::CMD_POP_MIN, $urandom(), $urandom());

        // random phases: fill to full, drain to empty, mixed traffic, noise
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode     = $urandom_range(3);
            key_span = $urandom_range(2);
            run_len  = (mode == MODE_FILL || mode == MODE_DRAIN) ?
                       $urandom_range(80, 120) : $urandom_range(30, 90);
            for (n = 0; n < run_len && sent < RANDOM_ITEMS; n++) begin
                steady = (sent >= 250 && sent < 420);
                pick   = $urandom_range(99);
                case (mode)
                    MODE_FILL:
                        cmd = (pick < 92) ? sdepq_pkg::CMD_INSERT :
                              (pick < 96) ? sdepq_pkg::CMD_POP_MIN : sdepq_pkg::CMD_POP_MAX;
                    MODE_DRAIN:
                        cmd = (pick < 6)  ? sdepq_pkg::CMD_INSERT :
                              (pick < 52) ? sdepq_pkg::CMD_POP_MIN :
                              (pick < 98) ? sdepq_pkg::CMD_POP_MAX : CMD_RESERVED;
                    MODE_MIXED:
                        cmd = (pick < 50) ? sdepq_pkg::CMD_INSERT :
                              (pick < 74) ? sdepq_pkg::CMD_POP_MIN :
                              (pick < 98) ? sdepq_pkg::CMD_POP_MAX : CMD_RESERVED;
                    default:
                        cmd = (pick < 30) ? sdepq_pkg::CMD_INSERT :
                              (pick < 55) ? sdepq_pkg::CMD_POP_MIN :
                              (pick < 80) ? sdepq_pkg::CMD_POP_MAX : CMD_RESERVED;
                endcase
                // narrow key spans force many equal keys
                case (key_span)
                    0: key = $urandom();
                    1: begin
                        narrow = int'($urandom_range(6)) - 3;
                        key    = narrow;
                    end
                    default: begin
                        case ($urandom_range(4))
                            0: key = 32'h8000_0000;
                            1: key = 32'h7FFF_FFFF;
                            2: key = 32'h0000_0000;
                            3: key = 32'hFFFF_FFFF;
                            default: key = $urandom();
                        endcase
                    end
                endcase
                send_cmd(cmd, key, $urandom());
                sent++;
            end
        end
        steady = 1'b0;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d inserts, %0d min removals, %0d max removals, %0d reserved codes",
                 sent_by_cmd[sdepq_pkg::CMD_INSERT], sent_by_cmd[sdepq_pkg::CMD_POP_MIN],
                 sent_by_cmd[sdepq_pkg::CMD_POP_MAX], sent_by_cmd[CMD_RESERVED]);
        $display("Checked %0d result beats, %0d refused, peak occupancy %0d of %0d",
                 result_count, refusal_count, peak_occupancy, DEPTH);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/sdepq_pkg.sv
hw/rtl/sdepq_cell.sv
hw/rtl/sdepq_chain.sv
hw/rtl/sorted_double_ended_priority_queue_top.sv
sim/sdepq_checker.sv
sim/tb_top.sv
